/* sv/tbs_pkg.sv */
// ----------------------------------------------------------------------------
// tbs_pkg - timestamp burst segmenter shared definitions
// Widths, register indexes, reset values, FSM states and the command/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package tbs_pkg;

  localparam int unsigned STAMP_W        = 64;
  localparam int unsigned MAX_STAMPS_DEF = 64;
  localparam int unsigned MAX_RESULTS    = 32;
  localparam int unsigned RES_CNT_W      = $clog2(MAX_RESULTS + 1);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DUR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUR = 2'd2;

  localparam logic [STAMP_W-1:0] MIN_GAP_RST = 64'd50000000;
  localparam logic [STAMP_W-1:0] MIN_DUR_RST = 64'd200000000;
  localparam logic [STAMP_W-1:0] MAX_DUR_RST = 64'd3000000000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_SCAN_START,
    ST_SCAN_FIRST,
    ST_GAP,
    ST_CLOSE,
    ST_QUAL,
    ST_FLUSH
  } tbs_state_t;

  typedef struct packed {
    logic accept;      // latch input item
    logic ins_read;    // read entry below insert position
    logic ins_shift;   // move read entry up one slot
    logic ins_place;   // write new stamp at insert position
    logic scan_init;   // clear result state, read entry 0
    logic scan_first;  // load first stamp, read entry 1
    logic gap_eval;    // register gap compares
    logic close_eval;  // pick closing stamp, register duration
    logic seg_take;    // qualify segment, reopen at current stamp
    logic advance;     // step to next entry
    logic flush;       // emit final result, clear list
  } tbs_cmd_t;

  typedef struct packed {
    logic full;
    logic few;
    logic pos_zero;
    logic rd_gt;
    logic last_pend;
    logic seg_close;
    logic is_final;
    logic qual;
    logic pend_valid;
    logic cnt_limit;
    logic out_free;
  } tbs_stat_t;

endpackage

/* sv/tbs_if.sv */
// ----------------------------------------------------------------------------
// tbs_if - stream channels of the timestamp burst segmenter
// Input channel carries stamps, output channel carries segment results.
// ----------------------------------------------------------------------------
interface tbs_in_if;
  import tbs_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAMP_W-1:0] stamp;
  logic               has_value;
  logic               last_item;

  modport source (output valid, stamp, has_value, last_item, input ready);
  modport sink   (input valid, stamp, has_value, last_item, output ready);
endinterface

interface tbs_out_if;
  import tbs_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAMP_W-1:0] seg_start;
  logic [STAMP_W-1:0] seg_end;
  logic               found;
  logic               dropped;
  logic               last_result;

  modport source (output valid, seg_start, seg_end, found, dropped, last_result,
                  input ready);
  modport sink   (input valid, seg_start, seg_end, found, dropped, last_result,
                  output ready);
endinterface

/* sv/tbs_ctrl.sv */
// ----------------------------------------------------------------------------
// tbs_ctrl - sequencer of the timestamp burst segmenter
// Walks the insertion sort and the segment scan, issuing datapath commands.
// ----------------------------------------------------------------------------
module tbs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_has_value,
  input  logic              in_last_item,
  output logic              in_ready,
  input  tbs_pkg::tbs_stat_t stat,
  output tbs_pkg::tbs_cmd_t  cmd
);
  import tbs_pkg::*;

  tbs_state_t state;
  tbs_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_has_value && !stat.full) begin
            state_next = ST_INS_RD;
          end else if (in_last_item) begin
            state_next = ST_SCAN_START;
          end
        end
      end
      ST_INS_RD: begin
        if (stat.pos_zero) begin
          cmd.ins_place = 1'b1;
          state_next    = stat.last_pend ? ST_SCAN_START : ST_IDLE;
        end else begin
          cmd.ins_read = 1'b1;
          state_next   = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (stat.rd_gt) begin
          cmd.ins_shift = 1'b1;
          state_next    = ST_INS_RD;
        end else begin
          cmd.ins_place = 1'b1;
          state_next    = stat.last_pend ? ST_SCAN_START : ST_IDLE;
        end
      end
      ST_SCAN_START: begin
        cmd.scan_init = 1'b1;
        state_next    = stat.few ? ST_FLUSH : ST_SCAN_FIRST;
      end
      ST_SCAN_FIRST: begin
        cmd.scan_first = 1'b1;
        state_next     = ST_GAP;
      end
      ST_GAP: begin
        cmd.gap_eval = 1'b1;
        state_next   = ST_CLOSE;
      end
      ST_CLOSE: begin
        if (stat.seg_close) begin
          cmd.close_eval = 1'b1;
          state_next     = ST_QUAL;
        end else begin
          cmd.advance = 1'b1;
          state_next  = ST_GAP;
        end
      end
      ST_QUAL: begin
        // a qualifying segment pushes the held one out; wait for room
        if (!(stat.qual && stat.pend_valid && !stat.out_free)) begin
          cmd.seg_take = 1'b1;
          if (stat.is_final || (stat.qual && stat.cnt_limit)) begin
            state_next = ST_FLUSH;
          end else begin
            cmd.advance = 1'b1;
            state_next  = ST_GAP;
          end
        end
      end
      ST_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/tbs_dpath.sv */
// ----------------------------------------------------------------------------
// tbs_dpath - datapath of the timestamp burst segmenter
// Stamp memory, sort and scan registers, config registers, output register.
// ----------------------------------------------------------------------------
module tbs_dpath #(
  parameter int unsigned MAX_STAMPS = tbs_pkg::MAX_STAMPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [tbs_pkg::STAMP_W-1:0]         stamp,
  input  logic                                has_value,
  input  logic                                last_item,
  input  logic                                cfg_we,
  input  logic [tbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tbs_pkg::STAMP_W-1:0]         cfg_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [tbs_pkg::STAMP_W-1:0]         seg_start,
  output logic [tbs_pkg::STAMP_W-1:0]         seg_end,
  output logic                                found,
  output logic                                dropped,
  output logic                                last_result,
  input  tbs_pkg::tbs_cmd_t                   cmd,
  output tbs_pkg::tbs_stat_t                  stat
);
  import tbs_pkg::*;

  localparam int unsigned AW = (MAX_STAMPS > 1) ? $clog2(MAX_STAMPS) : 1;
  localparam int unsigned CW = $clog2(MAX_STAMPS + 1);

  logic [STAMP_W-1:0] min_gap;
  logic [STAMP_W-1:0] min_dur;
  logic [STAMP_W-1:0] max_dur;

  logic [STAMP_W-1:0] mem [MAX_STAMPS];
  logic [STAMP_W-1:0] rdata;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [STAMP_W-1:0] wr_data;

  logic [STAMP_W-1:0] new_stamp;
  logic [AW-1:0]      pos;
  logic               last_pend;
  logic [CW-1:0]      fill;
  logic               ovf;

  logic [CW-1:0]      idx;
  logic [CW-1:0]      idx_p1;
  logic [STAMP_W-1:0] prev;
  logic [STAMP_W-1:0] cur;
  logic [STAMP_W-1:0] seg_open;
  logic [STAMP_W-1:0] seg_close;
  logic [STAMP_W-1:0] close_sel;
  logic [STAMP_W-1:0] dur;
  logic [STAMP_W-1:0] gap;
  logic               gap_gt;
  logic               gap_lt;
  logic               is_final;
  logic               qual;
  logic [RES_CNT_W-1:0] cnt;
  logic               pend_valid;
  logic [STAMP_W-1:0] pend_start;
  logic [STAMP_W-1:0] pend_end;
  logic               out_free;
  logic               out_load;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap <= MIN_GAP_RST;
      min_dur <= MIN_DUR_RST;
      max_dur <= MAX_DUR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_GAP: min_gap <= cfg_data;
        REG_MIN_DUR: min_dur <= cfg_data;
        REG_MAX_DUR: max_dur <= cfg_data;
        default: ;
      endcase
    end
  end

  // stamp memory: one write and one registered read per cycle
  assign idx_p1  = idx + CW'(1);
  assign rd_en   = cmd.ins_read | cmd.scan_init | cmd.scan_first | cmd.advance;
  assign wr_en   = cmd.ins_place | cmd.ins_shift;
  assign wr_data = cmd.ins_shift ? rdata : new_stamp;

  always_comb begin
    rd_addr = '0;
    if (cmd.ins_read) begin
      rd_addr = pos - AW'(1);
    end else if (cmd.scan_first) begin
      rd_addr = idx[AW-1:0];
    end else if (cmd.advance) begin
      rd_addr = idx_p1[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // load and insertion sort
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      ovf       <= 1'b0;
      last_pend <= 1'b0;
    end else begin
      if (cmd.accept) begin
        last_pend <= last_item;
        if (has_value && stat.full) begin
          ovf <= 1'b1;
        end
      end
      if (cmd.ins_place) begin
        fill <= fill + CW'(1);
      end
      if (cmd.flush) begin
        fill <= '0;
        ovf  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      new_stamp <= stamp;
      pos       <= fill[AW-1:0];
    end else if (cmd.ins_shift) begin
      pos <= pos - AW'(1);
    end
  end

  // scan
  assign gap       = rdata - prev;
  assign close_sel = (is_final && gap_lt) ? cur : prev;
  assign qual      = (dur > min_dur) && (dur < max_dur);

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      idx <= CW'(1);
    end else if (cmd.advance) begin
      idx <= idx_p1;
    end
    if (cmd.scan_first) begin
      seg_open <= rdata;
      prev     <= rdata;
    end
    if (cmd.gap_eval) begin
      cur      <= rdata;
      gap_gt   <= gap > min_gap;
      gap_lt   <= gap < min_gap;
      is_final <= idx == (fill - CW'(1));
    end
    if (cmd.close_eval) begin
      seg_close <= close_sel;
      dur       <= close_sel - seg_open;
    end
    if (cmd.seg_take) begin
      seg_open <= cur;
      if (qual) begin
        pend_start <= seg_open;
        pend_end   <= seg_close;
      end
    end
    if (cmd.advance) begin
      prev <= cur;
    end
  end

  // one segment is held back so the final one can carry last_result
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      cnt        <= '0;
    end else if (cmd.scan_init || cmd.flush) begin
      pend_valid <= 1'b0;
      cnt        <= '0;
    end else if (cmd.seg_take && qual) begin
      pend_valid <= 1'b1;
      cnt        <= cnt + RES_CNT_W'(1);
    end
  end

  // output register
  assign out_free = !out_valid || out_ready;
  assign out_load = cmd.flush || (cmd.seg_take && qual && pend_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      seg_start   <= pend_valid ? pend_start : '0;
      seg_end     <= pend_valid ? pend_end : '0;
      found       <= pend_valid;
      dropped     <= ovf;
      last_result <= cmd.flush;
    end
  end

  always_comb begin
    stat            = '0;
    stat.full       = fill == CW'(MAX_STAMPS);
    stat.few        = fill < CW'(2);
    stat.pos_zero   = pos == '0;
    stat.rd_gt      = rdata > new_stamp;
    stat.last_pend  = last_pend;
    stat.seg_close  = gap_gt || is_final;
    stat.is_final   = is_final;
    stat.qual       = qual;
    stat.pend_valid = pend_valid;
    stat.cnt_limit  = cnt == RES_CNT_W'(MAX_RESULTS - 1);
    stat.out_free   = out_free;
  end

endmodule

/* sv/timestamp_burst_segmenter_unit.sv */
// ----------------------------------------------------------------------------
// timestamp_burst_segmenter_unit - timestamp burst segmenter top level
// Sorts a list of timestamps as they arrive, then reports bursts of closely
// spaced stamps whose duration lies within the configured bounds.
//
//   channel    dir  handshake      payload
//   stamps     in   valid/ready    stamp[63:0], has_value, last_item
//   segments   out  valid/ready    seg_start, seg_end, found, dropped,
//                                  last_result
//   cfg        in   cfg_we         cfg_index[1:0], cfg_data[63:0]
//
// An item without a stamp needs no sort; a stamp reads the sorted entry below
// its insert position, compares it and shifts it up while it is greater, and is
// written where it lands (registered-read stamp memory, read-compare-write steps).
// The scan after last_item walks the sorted stamps and closes segments, or goes
// straight to the final result for fewer than two stamps; stamps is not
// ready meanwhile.
// Synchronous active-high reset; the stamp memory needs no clearing.
// The scan holds while a result is due and the output register is still full.
// ----------------------------------------------------------------------------
module timestamp_burst_segmenter_unit #(
  parameter int unsigned MAX_STAMPS = tbs_pkg::MAX_STAMPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  tbs_in_if.sink                        stamps,
  tbs_out_if.source                     segments,
  input  logic                          cfg_we,
  input  logic [tbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tbs_pkg::STAMP_W-1:0]   cfg_data
);
  import tbs_pkg::*;

  tbs_cmd_t  cmd;
  tbs_stat_t stat;

  tbs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (stamps.valid),
    .in_has_value (stamps.has_value),
    .in_last_item (stamps.last_item),
    .in_ready     (stamps.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  tbs_dpath #(
    .MAX_STAMPS (MAX_STAMPS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .stamp       (stamps.stamp),
    .has_value   (stamps.has_value),
    .last_item   (stamps.last_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_ready   (segments.ready),
    .out_valid   (segments.valid),
    .seg_start   (segments.seg_start),
    .seg_end     (segments.seg_end),
    .found       (segments.found),
    .dropped     (segments.dropped),
    .last_result (segments.last_result),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

/* sv/tbs_checker.sv */
// ----------------------------------------------------------------------------
// tbs_checker - port-level checks of the timestamp burst segmenter
// Watches the result channel; bound to the top level.
// ----------------------------------------------------------------------------
module tbs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tbs_pkg::STAMP_W-1:0] seg_start,
  input logic [tbs_pkg::STAMP_W-1:0] seg_end,
  input logic                        found,
  input logic                        dropped,
  input logic                        last_result
);
  import tbs_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(seg_start) && $stable(seg_end)
      && $stable(found) && $stable(dropped) && $stable(last_result))
    else $error("result changed while stalled");

  // an empty result stands alone for its list
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> last_result)
    else $error("empty result without last_result");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> seg_start == '0 && seg_end == '0)
    else $error("empty result with nonzero bounds");

  // sorted list and a strict lower duration bound give a positive length
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> seg_end > seg_start)
    else $error("segment end not after start");

endmodule

bind timestamp_burst_segmenter_unit tbs_checker u_tbs_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (segments.valid),
  .out_ready   (segments.ready),
  .seg_start   (segments.seg_start),
  .seg_end     (segments.seg_end),
  .found       (segments.found),
  .dropped     (segments.dropped),
  .last_result (segments.last_result)
);
